FILE: rtl/movt_pkg.sv
package movt_pkg;

    localparam int VERTEX_BITS  = 12;
    localparam int VERTEX_COUNT = 4096;
    localparam int DEGREE_BITS  = 16;
    localparam int S_TDATA_W    = 16;
    localparam int M_TDATA_W    = 32;
    localparam int CLR_BITS     = VERTEX_BITS + 1;

    localparam logic [DEGREE_BITS-1:0] DEG_MAX = {DEGREE_BITS{1'b1}};

    typedef struct packed {
        logic rd_en;
        logic upd_en;
    } tbl_req_t;

endpackage

FILE: rtl/movt_degree_table.sv
module movt_degree_table (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  movt_pkg::tbl_req_t                   req,
    input  logic [movt_pkg::VERTEX_BITS-1:0]     rd_addr,
    input  logic [movt_pkg::VERTEX_BITS-1:0]     upd_addr,
    output logic [movt_pkg::DEGREE_BITS-1:0]     new_cnt,
    output logic                                 clear_done
);

    logic [movt_pkg::DEGREE_BITS-1:0] mem [movt_pkg::VERTEX_COUNT];
    logic [movt_pkg::DEGREE_BITS-1:0] rdata_reg;

    logic [movt_pkg::CLR_BITS-1:0]    clr_cnt_reg;
    logic [movt_pkg::CLR_BITS-1:0]    clr_cnt_next;

    logic                             fwd_valid_reg;
    logic [movt_pkg::VERTEX_BITS-1:0] fwd_addr_reg;
    logic [movt_pkg::DEGREE_BITS-1:0] fwd_data_reg;

    logic                             wr_en;
    logic [movt_pkg::VERTEX_BITS-1:0] wr_addr;
    logic [movt_pkg::DEGREE_BITS-1:0] wr_data;
    logic [movt_pkg::DEGREE_BITS-1:0] cur_cnt;

    assign clear_done   = clr_cnt_reg[movt_pkg::VERTEX_BITS];
    assign clr_cnt_next = clr_cnt_reg + movt_pkg::CLR_BITS'(1);

    // latest write wins over the stale read
    always_comb begin
        if (fwd_valid_reg && (fwd_addr_reg == upd_addr)) begin
            cur_cnt = fwd_data_reg;
        end else begin
            cur_cnt = rdata_reg;
        end
        if (cur_cnt == movt_pkg::DEG_MAX) begin
            new_cnt = cur_cnt;
        end else begin
            new_cnt = cur_cnt + movt_pkg::DEGREE_BITS'(1);
        end
    end

    always_comb begin
        if (!clear_done) begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_reg[movt_pkg::VERTEX_BITS-1:0];
            wr_data = '0;
        end else begin
            wr_en   = req.upd_en;
            wr_addr = upd_addr;
            wr_data = new_cnt;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (req.rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg   <= '0;
            fwd_valid_reg <= 1'b0;
        end else begin
            if (!clear_done) begin
                clr_cnt_reg <= clr_cnt_next;
            end
            if (clear_done && req.upd_en) begin
                fwd_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.upd_en) begin
            fwd_addr_reg <= upd_addr;
            fwd_data_reg <= new_cnt;
        end
    end

endmodule

FILE: rtl/max_outdegree_vertex_tracker.sv
// pipeline: an accepted word is held in the s1 stage registers, then its result in the m output registers
// throughput: one word per cycle unless m_tready stalls the output; the degree table
// read-modify-write is forwarded between back-to-back words with the same source vertex
// reset: aresetn is synchronous; after it a clearing pass zeroes all 4096 entries of the
// degree table, one entry per cycle, and s_tready stays low until it ends
module max_outdegree_vertex_tracker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [movt_pkg::S_TDATA_W-1:0] s_tdata,  // src_vertex[11:0], zero pad
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [movt_pkg::M_TDATA_W-1:0] m_tdata,  // best_vertex[11:0], best_degree[27:12], pad
    output logic                           m_tlast
);

    movt_pkg::tbl_req_t               req;
    logic                             s_accept;
    logic                             adv;
    logic                             clear_done;
    logic                             in_range;
    logic                             take_top;
    logic [movt_pkg::DEGREE_BITS-1:0] new_cnt;

    logic                             s1_valid_reg;
    logic [movt_pkg::VERTEX_BITS-1:0] s1_vertex_reg;
    logic                             s1_last_reg;

    logic [movt_pkg::DEGREE_BITS-1:0] top_degree_reg;
    logic [movt_pkg::DEGREE_BITS-1:0] top_degree_next;
    logic [movt_pkg::VERTEX_BITS-1:0] top_vertex_reg;
    logic [movt_pkg::VERTEX_BITS-1:0] top_vertex_next;

    logic                             m_valid_reg;
    logic [movt_pkg::VERTEX_BITS-1:0] m_vertex_reg;
    logic [movt_pkg::DEGREE_BITS-1:0] m_degree_reg;
    logic                             m_last_reg;

    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = clear_done && (!s1_valid_reg || adv);
    assign s_accept = s_tvalid && s_tready;
    assign in_range = {1'b0, s1_vertex_reg} <
                      movt_pkg::CLR_BITS'(movt_pkg::VERTEX_COUNT);

    assign req.rd_en  = s_accept;
    assign req.upd_en = s1_valid_reg && adv && in_range;

    movt_degree_table u_table (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req        (req),
        .rd_addr    (s_tdata[movt_pkg::VERTEX_BITS-1:0]),
        .upd_addr   (s1_vertex_reg),
        .new_cnt    (new_cnt),
        .clear_done (clear_done)
    );

    // strictly greater takes over the best
    assign take_top = req.upd_en && (new_cnt > top_degree_reg);

    always_comb begin
        top_degree_next = top_degree_reg;
        top_vertex_next = top_vertex_reg;
        if (take_top) begin
            top_degree_next = new_cnt;
            top_vertex_next = s1_vertex_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            top_degree_reg <= '0;
            top_vertex_reg <= '0;
        end else begin
            if (s_accept) begin
                s1_valid_reg <= 1'b1;
            end else if (adv) begin
                s1_valid_reg <= 1'b0;
            end
            if (adv) begin
                m_valid_reg <= s1_valid_reg;
            end
            top_degree_reg <= top_degree_next;
            top_vertex_reg <= top_vertex_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_vertex_reg <= s_tdata[movt_pkg::VERTEX_BITS-1:0];
            s1_last_reg   <= s_tlast;
        end
        if (adv && s1_valid_reg) begin
            m_vertex_reg <= top_vertex_next;
            m_degree_reg <= top_degree_next;
            m_last_reg   <= s1_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {
        (movt_pkg::M_TDATA_W - movt_pkg::VERTEX_BITS - movt_pkg::DEGREE_BITS)'(0),
        m_degree_reg,
        m_vertex_reg
    };

`ifndef NO_ASSERTIONS
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !clear_done |-> !s_tready)
        else $error("word accepted during table clear");

    a_top_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> top_degree_reg >= $past(top_degree_reg))
        else $error("best degree went down");

    a_top_only_on_update: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && (top_degree_reg != $past(top_degree_reg)) |->
        $past(req.upd_en))
        else $error("best degree changed without a table update");

    a_stall_holds_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !adv |-> !s_accept)
        else $error("word accepted over a stalled stage");
`endif

endmodule
